@@ rtl/core/lbsc_pkg.sv @@
// Shared types, constants and the LFSR step function for the LFSR byte cipher.
// No dependencies; every other file imports this package.
package lbsc_pkg;

  localparam int unsigned STATE_W = 32;
  localparam int unsigned BYTE_W  = 8;

  // Feedback taps of the Fibonacci register
  localparam int unsigned TAP_HI  = 31;
  localparam int unsigned TAP_MID = 21;
  localparam int unsigned TAP_LO  = 1;

  localparam logic [STATE_W-1:0] STATE_RESET = '0;

  typedef logic [STATE_W-1:0] state_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  typedef enum logic {
    ACT_ENCRYPT = 1'b0,
    ACT_DECRYPT = 1'b1
  } action_t;

  // Keystream snapshot handed to the datapath for one word
  typedef struct packed {
    byte_t key_byte;   // bit 31 before each of the eight steps, MSB first
    logic  latch_bit;  // latched top bit left by the previous word
  } ks_t;

  function automatic state_t lfsr_step(input state_t s);
    logic fb;
    fb = s[TAP_HI] ^ s[TAP_LO] ^ s[TAP_MID];
    return {s[STATE_W-2:0], fb};
  endfunction

  function automatic state_t lfsr_step8(input state_t s);
    state_t t;
    t = s;
    for (int i = 0; i < BYTE_W; i++) begin
      t = lfsr_step(t);
    end
    return t;
  endfunction

endpackage

@@ rtl/core/lbsc_in_if.sv @@
// Input channel: valid/ready handshake carrying one word to encrypt or decrypt.
// Depends on lbsc_pkg.
interface lbsc_in_if;
  import lbsc_pkg::*;

  logic  valid;
  logic  ready;
  logic  action;
  byte_t data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

@@ rtl/core/lbsc_out_if.sv @@
// Output channel: valid/ready handshake carrying one result word.
// Depends on lbsc_pkg.
interface lbsc_out_if;
  import lbsc_pkg::*;

  logic  valid;
  logic  ready;
  byte_t result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink   (input valid, input result_byte, output ready);
endinterface

@@ rtl/core/lbsc_cfg_if.sv @@
// Configuration write channel: valid/ready handshake carrying the seed value.
// Depends on lbsc_pkg.
interface lbsc_cfg_if;
  import lbsc_pkg::*;

  logic   valid;
  logic   ready;
  state_t seed_value;

  modport source (output valid, output seed_value, input ready);
  modport sink   (input valid, input seed_value, output ready);
endinterface

@@ rtl/core/lbsc_keystream.sv @@
// Keystream generator: 32-bit LFSR state and latched key bit, advanced eight
// steps per word. Depends on lbsc_pkg.
module lbsc_keystream (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  lbsc_pkg::state_t seed,
  input  logic            advance,
  output lbsc_pkg::ks_t   ks
);
  import lbsc_pkg::*;

  state_t state;
  state_t state_next;
  logic   key_bit;

  assign state_next = lfsr_step8(state);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= STATE_RESET;
      key_bit <= 1'b0;
    end else if (load) begin
      state <= seed;
    end else if (advance) begin
      state   <= state_next;
      key_bit <= state_next[STATE_W-1];
    end
  end

  assign ks.key_byte  = state[STATE_W-1 -: BYTE_W];
  assign ks.latch_bit = key_bit;

  a_load: assert property (@(posedge clk) disable iff (rst)
    load |=> state == $past(seed))
    else $error("seed load not taken");

  a_shift: assert property (@(posedge clk) disable iff (rst)
    (advance && !load) |=> state[STATE_W-1:BYTE_W] == $past(state[STATE_W-BYTE_W-1:0]))
    else $error("state did not shift by one word");

  a_latch: assert property (@(posedge clk) disable iff (rst)
    (advance && !load) |=> key_bit == $past(state[STATE_W-BYTE_W-1]))
    else $error("latched key bit wrong");

endmodule

@@ rtl/core/lfsr_byte_stream_cipher.sv @@
// Byte stream cipher on a 32-bit Fibonacci LFSR (taps 31, 21, 1).
// Depends on lbsc_pkg, lbsc_in_if, lbsc_out_if, lbsc_cfg_if, lbsc_keystream.
//
// Usage:
//   cfg      : write channel; a word loads the seed into the LFSR. Always ready.
//              Write only while no word is in flight.
//   data_in  : one word per handshake: action (0 encrypt, 1 decrypt) and data_byte.
//   data_out : one result_byte per input word, in order.
// Path: a word accepted on data_in is loaded into the input register, then into
//   the result register, which presents it on data_out.
// Throughput: one word per cycle unless data_out stalls; the LFSR advances eight
//   steps on accept through unrolled XOR logic; the next word sees the new state.
// Reset: LFSR state and latched key bit clear to zero; both pipeline stages
//   empty.
// Stall: when data_out is held, the result register keeps its word and the
//   input register fills; data_in.ready drops only when both are full.
module lfsr_byte_stream_cipher (
  input logic          clk,
  input logic          rst,
  lbsc_cfg_if.sink     cfg,
  lbsc_in_if.sink      data_in,
  lbsc_out_if.source   data_out
);
  import lbsc_pkg::*;

  ks_t   ks;
  logic  in_fire;
  logic  s1_move;

  logic  s1_valid;
  logic  s1_action;
  byte_t s1_data;
  ks_t   s1_ks;
  byte_t s1_result;

  logic  out_valid;
  byte_t out_byte;

  assign cfg.ready = 1'b1;

  lbsc_keystream u_keystream (
    .clk     (clk),
    .rst     (rst),
    .load    (cfg.valid),
    .seed    (cfg.seed_value),
    .advance (in_fire),
    .ks      (ks)
  );

  assign s1_move      = s1_valid && (!out_valid || data_out.ready);
  assign data_in.ready = !s1_valid || s1_move;
  assign in_fire      = data_in.valid && data_in.ready;

  always_comb begin
    case (action_t'(s1_action))
      ACT_ENCRYPT: s1_result = s1_data ^ s1_ks.key_byte;
      ACT_DECRYPT: s1_result = s1_data ^ {s1_ks.latch_bit, s1_ks.key_byte[BYTE_W-1:1]};
      default:     s1_result = s1_data ^ s1_ks.key_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (data_out.ready) begin
        out_valid <= 1'b0;
      end
    end
    // payload
    if (in_fire) begin
      s1_action <= data_in.action;
      s1_data   <= data_in.data_byte;
      s1_ks     <= ks;
    end
    if (s1_move) begin
      out_byte <= s1_result;
    end
  end

  assign data_out.valid       = out_valid;
  assign data_out.result_byte = out_byte;

  a_fill: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> data_out.valid)
    else $error("staged word did not reach output");

  a_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && data_out.valid && !data_out.ready) |-> !data_in.ready)
    else $error("input taken while both stages full");

  a_rst: assert property (@(posedge clk)
    rst |=> !data_out.valid && !s1_valid)
    else $error("pipeline not empty after reset");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for lfsr_byte_stream_cipher: predicts each result word in a
// scoreboard class and drives random seeds, actions and bytes with random idling.
// Depends on lbsc_pkg, lbsc_in_if, lbsc_out_if, lbsc_cfg_if and the cipher RTL.
`timescale 1ns / 1ps

module tb_top;
  import lbsc_pkg::*;

  localparam int LIMIT_NS     = 400_000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_WORDS  = 118;
  localparam int HOLD_AT      = 300;  // result count at which the sink stalls
  localparam int HOLD_CYCLES  = 60;

  // Keeps its own copy of the shift register and key latch, and the queue of
  // result bytes still owed by the block.
  class cipher_board;
    state_t lfsr;
    logic   key_bit;
    byte_t  owed_bytes[$];
    int     errors;

    function new();
      lfsr    = '0;
      key_bit = 1'b0;
      errors  = 0;
    endfunction

    function state_t shift_once(state_t s);
      return {s[30:0], s[31] ^ s[21] ^ s[1]};
    endfunction

    // Seed write reloads the register; the key latch keeps its value
    function void load_seed(state_t seed);
      lfsr = seed;
    endfunction

    function void note_word(action_t act, byte_t d);
      byte_t res;
      if (act == ACT_ENCRYPT) begin
        for (int i = 7; i >= 0; i--) begin
          res[i] = d[i] ^ lfsr[31];
          lfsr   = shift_once(lfsr);
        end
      end else begin
        // MSB takes the latched key bit, then seven keyed steps and one blank step
        res[7] = d[7] ^ key_bit;
        for (int i = 6; i >= 0; i--) begin
          res[i] = d[i] ^ lfsr[31];
          lfsr   = shift_once(lfsr);
        end
        lfsr = shift_once(lfsr);
      end
      key_bit = lfsr[31];
      owed_bytes.push_back(res);
    endfunction

    function void check_word(byte_t got);
      byte_t exp;
      if (owed_bytes.size() == 0) begin
        $error("result_byte: no word expected, actual %02h", got);
        errors++;
      end else begin
        exp = owed_bytes.pop_front();
        if (exp !== got) begin
          $error("result_byte: expected %02h, actual %02h", exp, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return owed_bytes.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   tx_calm;
  bit   rx_calm;
  int   rx_count;

  lbsc_cfg_if cfg_bus ();
  lbsc_in_if  in_bus ();
  lbsc_out_if out_bus ();

  cipher_board board;

  lfsr_byte_stream_cipher uut (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_bus),
    .data_in  (in_bus),
    .data_out (out_bus)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("FAIL lfsr_byte_stream_cipher");
    $finish;
  end

  // Handshake monitor: all three channels sampled at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready)
        board.load_seed(cfg_bus.seed_value);
      if (in_bus.valid && in_bus.ready)
        board.note_word(action_t'(in_bus.action), in_bus.data_byte);
      if (out_bus.valid && out_bus.ready)
        board.check_word(out_bus.result_byte);
    end
  end

  // Result sink: random stalls, calm stretches, and one long hold-off
  initial begin
    int gap;
    out_bus.ready = 1'b0;
    rx_calm       = 1'b0;
    rx_count      = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0)
        rx_calm = !rx_calm;
      gap = rx_calm ? 0 : $urandom_range(0, 6);
      if (rx_count == HOLD_AT)
        gap = HOLD_CYCLES;
      if (gap != 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!(out_bus.valid && out_bus.ready)) @(posedge clk);
      rx_count++;
    end
  end

  task automatic send_word(input action_t act, input byte_t d);
    int gap;
    if ($urandom_range(0, 39) == 0)
      tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.action    <= act;
    in_bus.data_byte <= d;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every owed word has come back; the wait
  // begins once the last accepted word is already on the board
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_seed(input state_t seed);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.seed_value <= seed;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic byte_t rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    byte_t  edge_bytes[6];
    state_t seed;
    board = new();
    edge_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA};
    tx_calm            = 1'b0;
    rst                = 1'b1;
    in_bus.valid       = 1'b0;
    in_bus.action      = ACT_ENCRYPT;
    in_bus.data_byte   = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.seed_value = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state: zero register, key latch clear, decrypt before any encrypt
    send_word(ACT_DECRYPT, 8'hFF);
    send_word(ACT_ENCRYPT, 8'h00);
    send_word(ACT_ENCRYPT, 8'hA5);
    drain();

    write_seed(32'hFFFF_FFFF);
    foreach (edge_bytes[k]) begin
      send_word(ACT_ENCRYPT, edge_bytes[k]);
      send_word(ACT_DECRYPT, edge_bytes[k]);
    end
    drain();

    // Seed write leaves the key latch as the last word set it
    write_seed(32'h8000_0000);
    send_word(ACT_DECRYPT, 8'h80);
    send_word(ACT_DECRYPT, 8'h7F);
    send_word(ACT_ENCRYPT, 8'hFF);
    drain();
    write_seed(32'h0020_0002);
    send_word(ACT_DECRYPT, 8'h00);
    send_word(ACT_ENCRYPT, 8'h3C);
    send_word(ACT_DECRYPT, 8'hC3);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       seed = '0;
        1:       seed = '1;
        2:       seed = 32'h0000_0001;
        default: seed = state_t'($urandom);
      endcase
      write_seed(seed);
      for (int n = 0; n < PHASE_WORDS; n++)
        send_word(action_t'($urandom_range(0, 1)), rand_byte());
      drain();
    end

    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS lfsr_byte_stream_cipher");
    end else begin
      $display("FAIL lfsr_byte_stream_cipher");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/lbsc_pkg.sv
rtl/core/lbsc_in_if.sv
rtl/core/lbsc_out_if.sv
rtl/core/lbsc_cfg_if.sv
rtl/core/lbsc_keystream.sv
rtl/core/lfsr_byte_stream_cipher.sv
tb/tb_top.sv
